[rtl/assert_macros.svh]
// Assertion macros used by the port checker of this block.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define COMEST_ASSERT_IMP(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define COMEST_ASSERT_NXT(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error(msg);

`endif

[rtl/comest_pkg.sv]
// Shared types and constants of the clock offset median estimator.
package comest_pkg;

    localparam int TYPE_W = 8;
    localparam int TIME_W = 48;
    localparam int OFS_W = 49;

    // Configuration port.
    localparam int CFG_INDEX_W = 2;
    localparam int CFG_DATA_W = OFS_W;
    localparam logic [CFG_INDEX_W-1:0] REG_SYNC_TYPE = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_UNSET_OFFSET = 2'd1;

    // Samples gathered per median batch.
    localparam int SAMPLES_DEFAULT = 8;

    // Entries in the queue between the front and back parts.
    localparam int FIFO_DEPTH = 2;

    // One classified item handed from the front part to the back part.
    typedef struct packed {
        logic [TYPE_W-1:0]       type_code;
        logic [TIME_W-1:0]       msg_time;
        logic                    is_sync;
        logic signed [OFS_W-1:0] sample;
    } fe_item_t;

endpackage

[rtl/clock_offset_median_estimator_top.sv]
// Path: a message passes the front part's first and second stage, the queue and the
// back part's output register; the message that completes a batch also waits for the
// median search. The front part takes no new message until the last is handed on; the
// search reads the store over one port, one sample per cycle, once per candidate.
// Reset: aresetn is synchronous and active low; it clears the configuration, the
// offset state, the sample count, the queue and the pending result. The sample store is not cleared.
module clock_offset_median_estimator_top #(
    parameter int SAMPLES = comest_pkg::SAMPLES_DEFAULT
) (
    input  logic                                      aclk,
    input  logic                                      aresetn,
    // Configuration write channel.
    input  logic                                      cfg_valid,
    output logic                                      cfg_ready,
    input  logic [comest_pkg::CFG_INDEX_W-1:0]        cfg_index,
    input  logic [comest_pkg::CFG_DATA_W-1:0]         cfg_data,
    // Message input channel.
    input  logic                                      s_valid,
    output logic                                      s_ready,
    input  logic [comest_pkg::TYPE_W-1:0]             s_message_type,
    input  logic [comest_pkg::TIME_W-1:0]             s_message_time,
    input  logic [comest_pkg::TIME_W-1:0]             s_client_send_time,
    input  logic [comest_pkg::TIME_W-1:0]             s_server_stamp_time,
    input  logic [comest_pkg::TIME_W-1:0]             s_arrival_time,
    // Result output channel.
    output logic                                      m_valid,
    input  logic                                      m_ready,
    output logic [comest_pkg::TIME_W-1:0]             m_adjusted_time,
    output logic [comest_pkg::TYPE_W-1:0]             m_type_echo,
    output logic signed [comest_pkg::OFS_W-1:0]       m_current_offset,
    output logic                                      m_offset_accurate,
    output logic                                      m_median_updated
);

    logic [comest_pkg::TYPE_W-1:0]       sync_type_reg;
    logic signed [comest_pkg::OFS_W-1:0] unset_offset_reg;

    logic                 fe_valid, fe_ready;
    comest_pkg::fe_item_t fe_item;
    logic                 q_valid, q_ready;
    comest_pkg::fe_item_t q_item;

    assign cfg_ready = 1'b1;

    // Configuration registers; writes to unknown indexes are dropped.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sync_type_reg    <= '0;
            unset_offset_reg <= '0;
        end else if (cfg_valid && cfg_ready) begin
            case (cfg_index)
                comest_pkg::REG_SYNC_TYPE: begin
                    sync_type_reg <= cfg_data[comest_pkg::TYPE_W-1:0];
                end
                comest_pkg::REG_UNSET_OFFSET: begin
                    unset_offset_reg <= $signed(cfg_data);
                end
                default: begin
                end
            endcase
        end
    end

    comest_front u_front (
        .aclk                 (aclk),
        .aresetn              (aresetn),
        .sync_type            (sync_type_reg),
        .in_valid             (s_valid),
        .in_ready             (s_ready),
        .in_message_type      (s_message_type),
        .in_message_time      (s_message_time),
        .in_client_send_time  (s_client_send_time),
        .in_server_stamp_time (s_server_stamp_time),
        .in_arrival_time      (s_arrival_time),
        .out_valid            (fe_valid),
        .out_ready            (fe_ready),
        .out_item             (fe_item)
    );

    comest_fifo u_fifo (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (fe_valid),
        .in_ready  (fe_ready),
        .in_item   (fe_item),
        .out_valid (q_valid),
        .out_ready (q_ready),
        .out_item  (q_item)
    );

    comest_back #(
        .SAMPLES (SAMPLES)
    ) u_back (
        .aclk              (aclk),
        .aresetn           (aresetn),
        .unset_offset      (unset_offset_reg),
        .q_valid           (q_valid),
        .q_ready           (q_ready),
        .q_item            (q_item),
        .m_valid           (m_valid),
        .m_ready           (m_ready),
        .m_adjusted_time   (m_adjusted_time),
        .m_type_echo       (m_type_echo),
        .m_current_offset  (m_current_offset),
        .m_offset_accurate (m_offset_accurate),
        .m_median_updated  (m_median_updated)
    );

endmodule

[rtl/comest_ram.sv]
// Generic single-write, single-read memory with registered read data.
module comest_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 8
) (
    input  logic                                     aclk,
    input  logic                                     we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                         wdata,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write port and registered read port.
    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

[rtl/comest_fifo.sv]
// Short queue that decouples the front part from the back part.
module comest_fifo (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                in_valid,
    output logic                in_ready,
    input  comest_pkg::fe_item_t in_item,
    output logic                out_valid,
    input  logic                out_ready,
    output comest_pkg::fe_item_t out_item
);

    localparam int PW = (comest_pkg::FIFO_DEPTH > 1) ? $clog2(comest_pkg::FIFO_DEPTH) : 1;
    localparam int CW = $clog2(comest_pkg::FIFO_DEPTH + 1);
    localparam logic [CW-1:0] FULL_CNT = CW'(comest_pkg::FIFO_DEPTH);
    localparam logic [PW-1:0] LAST_PTR = PW'(comest_pkg::FIFO_DEPTH - 1);

    comest_pkg::fe_item_t entry_reg [comest_pkg::FIFO_DEPTH];
    logic [PW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0] count_reg, count_next;
    logic          push, pop;

    assign in_ready  = (count_reg != FULL_CNT);
    assign out_valid = (count_reg != '0);
    assign out_item  = entry_reg[rd_ptr_reg];
    assign push      = in_valid && in_ready;
    assign pop       = out_valid && out_ready;

    // Pointer and fill-count update.
    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push) begin
            wr_ptr_next = (wr_ptr_reg == LAST_PTR) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop) begin
            rd_ptr_next = (rd_ptr_reg == LAST_PTR) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop) begin
            count_next = count_reg + 1'b1;
        end else if (pop && !push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Entry storage needs no reset.
    always_ff @(posedge aclk) begin
        if (push) begin
            entry_reg[wr_ptr_reg] <= in_item;
        end
    end

endmodule

[rtl/comest_front.sv]
// Front part: accepts messages, classifies them and forms the offset sample.
module comest_front (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  logic [comest_pkg::TYPE_W-1:0]        sync_type,
    input  logic                                 in_valid,
    output logic                                 in_ready,
    input  logic [comest_pkg::TYPE_W-1:0]        in_message_type,
    input  logic [comest_pkg::TIME_W-1:0]        in_message_time,
    input  logic [comest_pkg::TIME_W-1:0]        in_client_send_time,
    input  logic [comest_pkg::TIME_W-1:0]        in_server_stamp_time,
    input  logic [comest_pkg::TIME_W-1:0]        in_arrival_time,
    output logic                                 out_valid,
    input  logic                                 out_ready,
    output comest_pkg::fe_item_t                 out_item
);

    localparam int OW = comest_pkg::OFS_W;
    localparam int WW = OW + 2;

    localparam logic [1:0] F_IDLE = 2'd0;
    localparam logic [1:0] F_CALC = 2'd1;
    localparam logic [1:0] F_PUSH = 2'd2;

    logic [1:0] state_reg, state_next;

    // First stage: the two differences and the classification.
    logic [comest_pkg::TYPE_W-1:0] type_reg;
    logic [comest_pkg::TIME_W-1:0] time_reg;
    logic                          sync_reg;
    logic signed [OW-1:0]          diff_reg;
    logic signed [OW-1:0]          rtt_reg;

    // Second stage: the saturated sample.
    comest_pkg::fe_item_t item_reg, item_next;

    logic signed [OW-1:0] half_floor;
    logic                 carry_in;
    logic signed [WW-1:0] sample_wide;
    logic signed [OW-1:0] sample_sat;

    assign in_ready  = (state_reg == F_IDLE);
    assign out_valid = (state_reg == F_PUSH);
    assign out_item  = item_reg;

    // Sample is diff - trunc(rtt / 2); the floor shift plus a carry-in gives the
    // truncation toward zero, so the subtract stays one adder.
    always_comb begin
        half_floor  = rtt_reg >>> 1;
        carry_in    = !(rtt_reg[OW-1] && rtt_reg[0]);
        sample_wide = {{2{diff_reg[OW-1]}}, diff_reg}
                    + ~{{2{half_floor[OW-1]}}, half_floor}
                    + {{(WW-1){1'b0}}, carry_in};
        if (sample_wide[WW-1:OW-1] == '0 || sample_wide[WW-1:OW-1] == '1) begin
            sample_sat = sample_wide[OW-1:0];
        end else if (!sample_wide[WW-1]) begin
            sample_sat = {1'b0, {(OW-1){1'b1}}};
        end else begin
            sample_sat = {1'b1, {(OW-1){1'b0}}};
        end
        item_next.type_code = type_reg;
        item_next.msg_time  = time_reg;
        item_next.is_sync   = sync_reg;
        item_next.sample    = sample_sat;
    end

    // Sequencer: accept, compute, hand over to the queue.
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            F_IDLE: begin
                if (in_valid) begin
                    state_next = F_CALC;
                end
            end
            F_CALC: begin
                state_next = F_PUSH;
            end
            F_PUSH: begin
                if (out_ready) begin
                    state_next = F_IDLE;
                end
            end
            default: begin
                state_next = F_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= F_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    // Datapath registers need no reset.
    always_ff @(posedge aclk) begin
        if (in_valid && in_ready) begin
            type_reg <= in_message_type;
            time_reg <= in_message_time;
            sync_reg <= (in_message_type == sync_type);
            diff_reg <= {1'b0, in_arrival_time} - {1'b0, in_server_stamp_time};
            rtt_reg  <= {1'b0, in_arrival_time} - {1'b0, in_client_send_time};
        end
        if (state_reg == F_CALC) begin
            item_reg <= item_next;
        end
    end

endmodule

[rtl/comest_back.sv]
// Back part: offset state, sample store and median selection.
module comest_back #(
    parameter int SAMPLES = comest_pkg::SAMPLES_DEFAULT
) (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  logic signed [comest_pkg::OFS_W-1:0]  unset_offset,
    input  logic                                 q_valid,
    output logic                                 q_ready,
    input  comest_pkg::fe_item_t                 q_item,
    output logic                                 m_valid,
    input  logic                                 m_ready,
    output logic [comest_pkg::TIME_W-1:0]        m_adjusted_time,
    output logic [comest_pkg::TYPE_W-1:0]        m_type_echo,
    output logic signed [comest_pkg::OFS_W-1:0]  m_current_offset,
    output logic                                 m_offset_accurate,
    output logic                                 m_median_updated
);

    localparam int OW = comest_pkg::OFS_W;
    localparam int AW = (SAMPLES > 1) ? $clog2(SAMPLES) : 1;
    localparam int CW = $clog2(SAMPLES + 1);
    localparam logic [CW-1:0] LAST_CNT = CW'(SAMPLES - 1);
    localparam logic [CW-1:0] FULL_CNT = CW'(SAMPLES);
    localparam logic [CW-1:0] MID_RANK = CW'(SAMPLES / 2);
    localparam logic [AW-1:0] FIRST_ADDR = '0;

    localparam logic [2:0] B_IDLE  = 3'd0;
    localparam logic [2:0] B_CAND  = 3'd1;
    localparam logic [2:0] B_CAPT  = 3'd2;
    localparam logic [2:0] B_SCAN  = 3'd3;
    localparam logic [2:0] B_CHECK = 3'd4;

    logic [2:0]            state_reg, state_next;
    logic [CW-1:0]         count_reg, count_next;
    logic signed [OW-1:0]  offset_reg, offset_next;
    logic                  offset_valid_reg, offset_valid_next;
    logic                  accurate_reg, accurate_next;
    logic [AW-1:0]         cand_idx_reg, cand_idx_next;
    logic signed [OW-1:0]  cand_reg, cand_next;
    logic [CW-1:0]         scan_reg, scan_next;
    logic [CW-1:0]         lt_reg, lt_next;
    logic [CW-1:0]         le_reg, le_next;
    logic [comest_pkg::TIME_W-1:0] pend_time_reg, pend_time_next;
    logic [comest_pkg::TYPE_W-1:0] pend_type_reg, pend_type_next;

    logic                          m_valid_reg, m_valid_next;
    logic [comest_pkg::TIME_W-1:0] m_time_reg, m_time_next;
    logic [comest_pkg::TYPE_W-1:0] m_type_reg, m_type_next;
    logic signed [OW-1:0]          m_offset_reg, m_offset_next;
    logic                          m_accurate_reg, m_accurate_next;
    logic                          m_median_reg, m_median_next;

    logic                  ram_we;
    logic [AW-1:0]         ram_raddr;
    logic [OW-1:0]         ram_rdata;
    logic signed [OW-1:0]  stored;
    logic signed [OW-1:0]  offset_before;
    logic [comest_pkg::TIME_W-1:0] adjusted;
    logic                  out_free;

    // Sample store; entries are read only after being written in this batch.
    comest_ram #(
        .WIDTH (OW),
        .DEPTH (SAMPLES)
    ) u_store (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (count_reg[AW-1:0]),
        .wdata (q_item.sample),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    assign stored        = $signed(ram_rdata);
    assign offset_before = offset_valid_reg ? offset_reg : unset_offset;
    assign adjusted      = q_item.msg_time + offset_before[comest_pkg::TIME_W-1:0];
    assign out_free      = !m_valid_reg || m_ready;
    assign q_ready       = (state_reg == B_IDLE) && out_free;

    assign m_valid           = m_valid_reg;
    assign m_adjusted_time   = m_time_reg;
    assign m_type_echo       = m_type_reg;
    assign m_current_offset  = m_offset_reg;
    assign m_offset_accurate = m_accurate_reg;
    assign m_median_updated  = m_median_reg;

    // Item execution and the median search. The search tries each stored
    // sample as a candidate, counts the samples below and at-or-below it, and
    // stops at the one whose rank range covers the middle position.
    always_comb begin
        state_next        = state_reg;
        count_next        = count_reg;
        offset_next       = offset_reg;
        offset_valid_next = offset_valid_reg;
        accurate_next     = accurate_reg;
        cand_idx_next     = cand_idx_reg;
        cand_next         = cand_reg;
        scan_next         = scan_reg;
        lt_next           = lt_reg;
        le_next           = le_reg;
        pend_time_next    = pend_time_reg;
        pend_type_next    = pend_type_reg;
        m_valid_next      = m_valid_reg;
        m_time_next       = m_time_reg;
        m_type_next       = m_type_reg;
        m_offset_next     = m_offset_reg;
        m_accurate_next   = m_accurate_reg;
        m_median_next     = m_median_reg;
        ram_we            = 1'b0;
        ram_raddr         = FIRST_ADDR;

        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end

        case (state_reg)
            B_IDLE: begin
                if (q_valid && out_free) begin
                    pend_time_next  = adjusted;
                    pend_type_next  = q_item.type_code;
                    m_time_next     = adjusted;
                    m_type_next     = q_item.type_code;
                    m_offset_next   = offset_before;
                    m_accurate_next = accurate_reg;
                    m_median_next   = 1'b0;
                    if (q_item.is_sync) begin
                        ram_we = 1'b1;
                        if (!offset_valid_reg) begin
                            offset_next       = q_item.sample;
                            offset_valid_next = 1'b1;
                            m_offset_next     = q_item.sample;
                        end
                        if (count_reg == LAST_CNT) begin
                            state_next    = B_CAND;
                            cand_idx_next = FIRST_ADDR;
                        end else begin
                            count_next   = count_reg + 1'b1;
                            m_valid_next = 1'b1;
                        end
                    end else begin
                        m_valid_next = 1'b1;
                    end
                end
            end
            B_CAND: begin
                ram_raddr  = cand_idx_reg;
                state_next = B_CAPT;
            end
            B_CAPT: begin
                cand_next  = stored;
                scan_next  = '0;
                lt_next    = '0;
                le_next    = '0;
                state_next = B_SCAN;
            end
            B_SCAN: begin
                if (scan_reg != FULL_CNT) begin
                    ram_raddr = scan_reg[AW-1:0];
                    scan_next = scan_reg + 1'b1;
                end else begin
                    state_next = B_CHECK;
                end
                // Read data is registered and answers the address of the cycle before.
                if (scan_reg != '0) begin
                    if (stored < cand_reg) begin
                        lt_next = lt_reg + 1'b1;
                    end
                    if (stored <= cand_reg) begin
                        le_next = le_reg + 1'b1;
                    end
                end
            end
            B_CHECK: begin
                if (lt_reg <= MID_RANK && le_reg > MID_RANK) begin
                    offset_next       = cand_reg;
                    offset_valid_next = 1'b1;
                    accurate_next     = 1'b1;
                    count_next        = '0;
                    state_next        = B_IDLE;
                    m_valid_next      = 1'b1;
                    m_time_next       = pend_time_reg;
                    m_type_next       = pend_type_reg;
                    m_offset_next     = cand_reg;
                    m_accurate_next   = 1'b1;
                    m_median_next     = 1'b1;
                end else begin
                    cand_idx_next = cand_idx_reg + 1'b1;
                    state_next    = B_CAND;
                end
            end
            default: begin
                state_next = B_IDLE;
            end
        endcase
    end

    // Control state.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg        <= B_IDLE;
            count_reg        <= '0;
            offset_valid_reg <= 1'b0;
            accurate_reg     <= 1'b0;
            m_valid_reg      <= 1'b0;
        end else begin
            state_reg        <= state_next;
            count_reg        <= count_next;
            offset_valid_reg <= offset_valid_next;
            accurate_reg     <= accurate_next;
            m_valid_reg      <= m_valid_next;
        end
    end

    // Payload and search registers.
    always_ff @(posedge aclk) begin
        offset_reg     <= offset_next;
        cand_idx_reg   <= cand_idx_next;
        cand_reg       <= cand_next;
        scan_reg       <= scan_next;
        lt_reg         <= lt_next;
        le_reg         <= le_next;
        pend_time_reg  <= pend_time_next;
        pend_type_reg  <= pend_type_next;
        m_time_reg     <= m_time_next;
        m_type_reg     <= m_type_next;
        m_offset_reg   <= m_offset_next;
        m_accurate_reg <= m_accurate_next;
        m_median_reg   <= m_median_next;
    end

endmodule

[rtl/comest_checker.sv]
// Port-level checker for the clock offset median estimator, with its bind.
`include "assert_macros.svh"

module comest_port_checker (
    input logic                              aclk,
    input logic                              aresetn,
    input logic                              m_valid,
    input logic                              m_ready,
    input logic [comest_pkg::TIME_W-1:0]     m_adjusted_time,
    input logic                              m_offset_accurate,
    input logic                              m_median_updated
);

    // A median update always leaves the offset marked accurate.
    `COMEST_ASSERT_IMP(a_median_accurate, aclk, aresetn, m_valid && m_median_updated, m_offset_accurate, "median update without accurate flag")

    // A result offered right after an accepted accurate result is accurate too.
    `COMEST_ASSERT_NXT(a_accurate_sticky, aclk, aresetn, m_valid && m_ready && m_offset_accurate, !m_valid || m_offset_accurate, "accurate flag dropped")

    // No result is offered in the first cycle after reset is released.
    `COMEST_ASSERT_IMP(a_reset_empty, aclk, aresetn, $rose(aresetn), !m_valid, "result present right after reset")

    // A stalled result transaction holds its timestamp.
    `COMEST_ASSERT_NXT(a_stall_hold, aclk, aresetn, m_valid && !m_ready, m_valid && $stable(m_adjusted_time), "stalled result changed")

endmodule

bind clock_offset_median_estimator_top comest_port_checker u_comest_checker (.*);

[verif/comest_checker.sv]
// Checker for the clock offset median estimator: predicts each result and compares it.
`timescale 1ns / 1ps

module comest_checker #(
    parameter int SAMPLES = comest_pkg::SAMPLES_DEFAULT
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                cfg_valid,
    input  logic                                cfg_ready,
    input  logic [comest_pkg::CFG_INDEX_W-1:0]  cfg_index,
    input  logic [comest_pkg::CFG_DATA_W-1:0]   cfg_data,
    input  logic                                s_valid,
    input  logic                                s_ready,
    input  logic [comest_pkg::TYPE_W-1:0]       s_message_type,
    input  logic [comest_pkg::TIME_W-1:0]       s_message_time,
    input  logic [comest_pkg::TIME_W-1:0]       s_client_send_time,
    input  logic [comest_pkg::TIME_W-1:0]       s_server_stamp_time,
    input  logic [comest_pkg::TIME_W-1:0]       s_arrival_time,
    input  logic                                m_valid,
    input  logic                                m_ready,
    input  logic [comest_pkg::TIME_W-1:0]       m_adjusted_time,
    input  logic [comest_pkg::TYPE_W-1:0]       m_type_echo,
    input  logic signed [comest_pkg::OFS_W-1:0] m_current_offset,
    input  logic                                m_offset_accurate,
    input  logic                                m_median_updated,
    output int                                  mismatch_count,
    output int                                  outstanding
);

    localparam int TYPE_W = comest_pkg::TYPE_W;
    localparam int TIME_W = comest_pkg::TIME_W;
    localparam int OFS_W = comest_pkg::OFS_W;
    localparam longint SAMPLE_MAX = 64'sd281474976710655;
    localparam longint SAMPLE_MIN = -64'sd281474976710656;
    localparam int REPORT_LIMIT = 10;

    typedef struct packed {
        logic [TIME_W-1:0]       adjusted_time;
        logic [TYPE_W-1:0]       type_echo;
        logic signed [OFS_W-1:0] current_offset;
        logic                    offset_accurate;
        logic                    median_updated;
    } offset_result_t;

    // Shadow copy of the configuration registers.
    logic [TYPE_W-1:0]       sync_code;
    logic signed [OFS_W-1:0] unset_offset;

    // Shadow copy of the estimator state.
    logic signed [OFS_W-1:0] batch_samples [SAMPLES];
    int unsigned             batch_fill;
    logic signed [OFS_W-1:0] held_offset;
    logic                    held_valid;
    logic                    accurate;

    offset_result_t expected_results [$];
    int             fails = 0;

    // Computes the result of one message and advances the shadow state.
    function automatic offset_result_t predict_offset_result(
        input logic [TYPE_W-1:0] mtype,
        input logic [TIME_W-1:0] mtime,
        input logic [TIME_W-1:0] csend,
        input logic [TIME_W-1:0] sstamp,
        input logic [TIME_W-1:0] arrive
    );
        offset_result_t          r;
        logic signed [OFS_W-1:0] offset_prev;
        logic signed [OFS_W-1:0] ordered [SAMPLES];
        logic signed [OFS_W-1:0] key;
        longint                  rtt;
        longint                  smp;
        int                      i;
        int                      j;

        offset_prev = held_valid ? held_offset : unset_offset;
        r.adjusted_time = mtime + offset_prev[TIME_W-1:0];
        r.median_updated = 1'b0;

        if (mtype == sync_code) begin
            // Sample: arrival minus server time minus half the round trip.
            rtt = longint'(arrive) - longint'(csend);
            smp = longint'(arrive) - longint'(sstamp) - rtt / 2;
            if (smp > SAMPLE_MAX) begin
                smp = SAMPLE_MAX;
            end
            if (smp < SAMPLE_MIN) begin
                smp = SAMPLE_MIN;
            end

            // The very first sample is used as the offset right away.
            if (!held_valid) begin
                held_offset = smp[OFS_W-1:0];
                held_valid = 1'b1;
            end
            if (batch_fill < SAMPLES) begin
                batch_samples[batch_fill] = smp[OFS_W-1:0];
            end
            batch_fill++;

            // A full batch replaces the offset by its median.
            if (batch_fill >= SAMPLES) begin
                for (i = 0; i < SAMPLES; i++) begin
                    ordered[i] = batch_samples[i];
                end
                for (i = 1; i < SAMPLES; i++) begin
                    key = ordered[i];
                    j = i - 1;
                    while (j >= 0 && ordered[j] > key) begin
                        ordered[j + 1] = ordered[j];
                        j--;
                    end
                    ordered[j + 1] = key;
                end
                held_offset = ordered[SAMPLES / 2];
                held_valid = 1'b1;
                batch_fill = 0;
                accurate = 1'b1;
                r.median_updated = 1'b1;
            end
        end

        r.type_echo = mtype;
        r.current_offset = held_valid ? held_offset : unset_offset;
        r.offset_accurate = accurate;
        return r;
    endfunction

    // Track configuration, predict on accepted messages, compare accepted results.
    always @(posedge aclk) begin : monitor
        offset_result_t got;
        offset_result_t want;
        offset_result_t pred;

        if (!aresetn) begin
            sync_code = '0;
            unset_offset = '0;
            batch_fill = 0;
            held_offset = '0;
            held_valid = 1'b0;
            accurate = 1'b0;
            expected_results.delete();
        end else begin
            if (cfg_valid && cfg_ready) begin
                case (cfg_index)
                    comest_pkg::REG_SYNC_TYPE: begin
                        sync_code = cfg_data[TYPE_W-1:0];
                    end
                    comest_pkg::REG_UNSET_OFFSET: begin
                        unset_offset = cfg_data;
                    end
                    default: begin
                    end
                endcase
            end

            if (m_valid && m_ready) begin
                got.adjusted_time = m_adjusted_time;
                got.type_echo = m_type_echo;
                got.current_offset = m_current_offset;
                got.offset_accurate = m_offset_accurate;
                got.median_updated = m_median_updated;
                if (expected_results.size() == 0) begin
                    fails++;
                    if (fails <= REPORT_LIMIT) begin
                        $display("%0t: unexpected result transaction: time %h type %h offset %0d acc %b med %b",
                                 $realtime, got.adjusted_time, got.type_echo, got.current_offset,
                                 got.offset_accurate, got.median_updated);
                    end
                end else begin
                    want = expected_results.pop_front();
                    if (got !== want) begin
                        fails++;
                        if (fails <= REPORT_LIMIT) begin
                            $display("%0t: result mismatch: expected time %h type %h offset %0d acc %b med %b",
                                     $realtime, want.adjusted_time, want.type_echo,
                                     want.current_offset, want.offset_accurate,
                                     want.median_updated);
                            $display("%0t:                  actual time %h type %h offset %0d acc %b med %b",
                                     $realtime, got.adjusted_time, got.type_echo,
                                     got.current_offset, got.offset_accurate,
                                     got.median_updated);
                        end
                    end
                end
            end

            if (s_valid && s_ready) begin
                pred = predict_offset_result(s_message_type, s_message_time,
                                             s_client_send_time, s_server_stamp_time,
                                             s_arrival_time);
                expected_results.insert(expected_results.size(), pred);
            end
        end

        mismatch_count <= fails;
        outstanding <= expected_results.size();
    end

endmodule

[verif/testbench.sv]
// Top of the clock offset median estimator testbench: clock, reset, stimulus and verdict.
`timescale 1ns / 1ps

module testbench;

    localparam int TYPE_W = comest_pkg::TYPE_W;
    localparam int TIME_W = comest_pkg::TIME_W;
    localparam int OFS_W = comest_pkg::OFS_W;
    localparam int CFG_INDEX_W = comest_pkg::CFG_INDEX_W;
    localparam int CFG_DATA_W = comest_pkg::CFG_DATA_W;
    localparam int SAMPLES = comest_pkg::SAMPLES_DEFAULT;
    localparam int PHASE_ITEMS = 450;
    localparam int HOLD_CYCLES = 300;
    localparam int WATCHDOG_LIMIT = 4000;
    localparam int DRAIN_CYCLES = SAMPLES * (SAMPLES + 4) + 16;

    // Indexes that map to no register; writes to them must be ignored.
    localparam logic [CFG_INDEX_W-1:0] REG_UNMAPPED_A = 2'd2;
    localparam logic [CFG_INDEX_W-1:0] REG_UNMAPPED_B = 2'd3;

    localparam logic signed [OFS_W-1:0] OFFSET_MAX = {1'b0, {TIME_W{1'b1}}};
    localparam logic signed [OFS_W-1:0] OFFSET_MIN = {1'b1, {TIME_W{1'b0}}};
    localparam logic [TIME_W-1:0]       TIME_MAX = {TIME_W{1'b1}};
    localparam logic [TYPE_W-1:0]       DIRECTED_SYNC = 8'hA5;

    typedef struct packed {
        logic [TYPE_W-1:0] message_type;
        logic [TIME_W-1:0] message_time;
        logic [TIME_W-1:0] client_send_time;
        logic [TIME_W-1:0] server_stamp_time;
        logic [TIME_W-1:0] arrival_time;
    } message_t;

    logic                    aclk;
    logic                    aresetn = 1'b0;
    logic                    cfg_valid = 1'b0;
    logic                    cfg_ready;
    logic [CFG_INDEX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0]   cfg_data = '0;
    logic                    s_valid = 1'b0;
    logic                    s_ready;
    logic [TYPE_W-1:0]       s_message_type = '0;
    logic [TIME_W-1:0]       s_message_time = '0;
    logic [TIME_W-1:0]       s_client_send_time = '0;
    logic [TIME_W-1:0]       s_server_stamp_time = '0;
    logic [TIME_W-1:0]       s_arrival_time = '0;
    logic                    m_valid;
    logic                    m_ready = 1'b0;
    logic [TIME_W-1:0]       m_adjusted_time;
    logic [TYPE_W-1:0]       m_type_echo;
    logic signed [OFS_W-1:0] m_current_offset;
    logic                    m_offset_accurate;
    logic                    m_median_updated;

    int          mismatch_count;
    int          outstanding;
    int unsigned src_idle_pct = 0;
    int unsigned sink_idle_pct = 0;
    logic        hold_request = 1'b0;
    logic        hold_served = 1'b0;
    int unsigned stuck_cycles = 0;
    logic [TYPE_W-1:0] sync_setting = DIRECTED_SYNC;

    clock_offset_median_estimator_top #(
        .SAMPLES(SAMPLES)
    ) u_top (
        .aclk               (aclk),
        .aresetn            (aresetn),
        .cfg_valid          (cfg_valid),
        .cfg_ready          (cfg_ready),
        .cfg_index          (cfg_index),
        .cfg_data           (cfg_data),
        .s_valid            (s_valid),
        .s_ready            (s_ready),
        .s_message_type     (s_message_type),
        .s_message_time     (s_message_time),
        .s_client_send_time (s_client_send_time),
        .s_server_stamp_time(s_server_stamp_time),
        .s_arrival_time     (s_arrival_time),
        .m_valid            (m_valid),
        .m_ready            (m_ready),
        .m_adjusted_time    (m_adjusted_time),
        .m_type_echo        (m_type_echo),
        .m_current_offset   (m_current_offset),
        .m_offset_accurate  (m_offset_accurate),
        .m_median_updated   (m_median_updated)
    );

    comest_checker #(
        .SAMPLES(SAMPLES)
    ) u_checker (
        .aclk               (aclk),
        .aresetn            (aresetn),
        .cfg_valid          (cfg_valid),
        .cfg_ready          (cfg_ready),
        .cfg_index          (cfg_index),
        .cfg_data           (cfg_data),
        .s_valid            (s_valid),
        .s_ready            (s_ready),
        .s_message_type     (s_message_type),
        .s_message_time     (s_message_time),
        .s_client_send_time (s_client_send_time),
        .s_server_stamp_time(s_server_stamp_time),
        .s_arrival_time     (s_arrival_time),
        .m_valid            (m_valid),
        .m_ready            (m_ready),
        .m_adjusted_time    (m_adjusted_time),
        .m_type_echo        (m_type_echo),
        .m_current_offset   (m_current_offset),
        .m_offset_accurate  (m_offset_accurate),
        .m_median_updated   (m_median_updated),
        .mismatch_count     (mismatch_count),
        .outstanding        (outstanding)
    );

    // Free-running clock.
    initial begin
        aclk = 1'b0;
        forever #4 aclk = ~aclk;
    end

    // Result receiver: random back-pressure plus one long hold-off on request.
    initial begin : result_sink
        int unsigned k;
        forever begin
            @(posedge aclk);
            if (hold_request && !hold_served) begin
                hold_served = 1'b1;
                for (k = 0; k < HOLD_CYCLES; k++) begin
                    m_ready <= 1'b0;
                    @(posedge aclk);
                end
            end
            m_ready <= ($urandom_range(99) >= sink_idle_pct);
        end
    end

    // Watchdog: ends the run when no transaction of any kind completes for too long.
    always @(posedge aclk) begin
        if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready) || (cfg_valid && cfg_ready)) begin
            stuck_cycles <= 0;
        end else begin
            stuck_cycles <= stuck_cycles + 1;
        end
        if (stuck_cycles >= WATCHDOG_LIMIT) begin
            $display("Mismatches found");
            $finish;
        end
    end

    function automatic message_t make_msg(
        input logic [TYPE_W-1:0] mtype,
        input logic [TIME_W-1:0] mtime,
        input logic [TIME_W-1:0] csend,
        input logic [TIME_W-1:0] sstamp,
        input logic [TIME_W-1:0] arrive
    );
        message_t m;
        m.message_type = mtype;
        m.message_time = mtime;
        m.client_send_time = csend;
        m.server_stamp_time = sstamp;
        m.arrival_time = arrive;
        return m;
    endfunction

    // Random 48-bit time with extra weight on both ends of the range.
    function automatic logic [TIME_W-1:0] random_time();
        logic [63:0] raw;
        raw = {$urandom, $urandom};
        case ($urandom_range(9))
            0: return '0;
            1: return TIME_MAX;
            default: return raw[TIME_W-1:0];
        endcase
    endfunction

    // Mostly sync replies, many well-formed around a plausible offset; the rest noise.
    function automatic message_t random_msg();
        message_t    m;
        logic [63:0] raw;
        logic [TIME_W-1:0] skew;
        logic [TIME_W-1:0] rtt;

        m = make_msg(TYPE_W'($urandom_range(255)), random_time(), random_time(),
                     random_time(), random_time());
        if ($urandom_range(99) < 60) begin
            m.message_type = sync_setting;
            if ($urandom_range(99) < 70) begin
                raw = {$urandom, $urandom};
                if ($urandom_range(1) == 0) begin
                    skew = TIME_W'($urandom_range(4000)) - TIME_W'(2000);
                end else begin
                    skew = raw[TIME_W-1:0];
                end
                rtt = TIME_W'($urandom_range(20000));
                m.arrival_time = m.client_send_time + rtt;
                m.server_stamp_time = m.client_send_time + (rtt >> 1) - skew;
            end
        end
        return m;
    endfunction

    // Leaves cfg_valid high; the caller lowers it after the last write of a group.
    task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(posedge aclk);
        while (!cfg_ready) begin
            @(posedge aclk);
        end
    endtask

    // Offers one message after a random gap; returns at the edge that accepts it.
    task automatic offer_msg(input message_t m);
        while ($urandom_range(99) < src_idle_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_message_type <= m.message_type;
        s_message_time <= m.message_time;
        s_client_send_time <= m.client_send_time;
        s_server_stamp_time <= m.server_stamp_time;
        s_arrival_time <= m.arrival_time;
        @(posedge aclk);
        while (!s_ready) begin
            @(posedge aclk);
        end
    endtask

    // Stops offering and waits until every predicted result has been seen.
    task automatic drain_results();
        s_valid <= 1'b0;
        @(posedge aclk);
        while (outstanding != 0) begin
            @(posedge aclk);
        end
    endtask

    task automatic run_random(input int unsigned count);
        int unsigned n;
        for (n = 0; n < count; n++) begin
            offer_msg(random_msg());
        end
    endtask

    // Stimulus: directed cases, then three random phases with different idling.
    initial begin : stimulus
        logic [63:0] raw;

        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;

        // Directed: offset taken from the unset register before any sample.
        raw = {$urandom, $urandom};
        write_reg(comest_pkg::REG_SYNC_TYPE, CFG_DATA_W'(DIRECTED_SYNC));
        write_reg(comest_pkg::REG_UNSET_OFFSET, OFFSET_MAX);
        write_reg(REG_UNMAPPED_A, raw[CFG_DATA_W-1:0]);
        write_reg(REG_UNMAPPED_B, ~raw[CFG_DATA_W-1:0]);
        cfg_valid <= 1'b0;
        offer_msg(make_msg(8'h00, '0, '0, '0, '0));
        offer_msg(make_msg(8'hFF, TIME_MAX, TIME_MAX, TIME_MAX, TIME_MAX));
        drain_results();

        write_reg(comest_pkg::REG_UNSET_OFFSET, OFFSET_MIN);
        cfg_valid <= 1'b0;
        offer_msg(make_msg(8'h00, TIME_MAX, '0, TIME_MAX, '0));
        drain_results();

        write_reg(comest_pkg::REG_UNSET_OFFSET, -49'sd5);
        cfg_valid <= 1'b0;
        offer_msg(make_msg(8'hA4, 48'd3, TIME_MAX, '0, TIME_MAX));

        // Directed sync replies: first sample, odd negative round trip, range ends,
        // repeated values, and the message that completes the batch.
        offer_msg(make_msg(DIRECTED_SYNC, '0, 48'd900, 48'd400, 48'd1000));
        offer_msg(make_msg(DIRECTED_SYNC, TIME_MAX, 48'd13, 48'd20, 48'd10));
        offer_msg(make_msg(DIRECTED_SYNC, 48'd7, TIME_MAX, '0, TIME_MAX));
        offer_msg(make_msg(DIRECTED_SYNC, TIME_MAX, '0, TIME_MAX, '0));
        offer_msg(make_msg(DIRECTED_SYNC, '0, TIME_MAX, '0, '0));
        offer_msg(make_msg(DIRECTED_SYNC, 48'd1, '0, TIME_MAX, TIME_MAX));
        offer_msg(make_msg(DIRECTED_SYNC, 48'd2, 48'd900, 48'd400, 48'd1000));
        offer_msg(make_msg(DIRECTED_SYNC, 48'd3, 48'd900, 48'd400, 48'd1000));
        offer_msg(make_msg(8'h00, TIME_MAX, '0, '0, '0));
        offer_msg(make_msg(8'hFF, '0, TIME_MAX, TIME_MAX, TIME_MAX));
        offer_msg(make_msg(DIRECTED_SYNC, TIME_MAX, 48'd5, 48'd5, 48'd6));
        drain_results();

        // Sender idles rarely, receiver often; highest type code selects sync.
        raw = {$urandom, $urandom};
        sync_setting = 8'hFF;
        write_reg(comest_pkg::REG_SYNC_TYPE, CFG_DATA_W'(sync_setting));
        write_reg(comest_pkg::REG_UNSET_OFFSET, raw[CFG_DATA_W-1:0]);
        cfg_valid <= 1'b0;
        src_idle_pct = 12;
        sink_idle_pct <= 62;
        run_random(PHASE_ITEMS);
        drain_results();

        // Roles swapped; lowest type code selects sync; one full pause mid-phase.
        sync_setting = 8'h00;
        write_reg(comest_pkg::REG_SYNC_TYPE, CFG_DATA_W'(sync_setting));
        write_reg(comest_pkg::REG_UNSET_OFFSET, OFFSET_MAX);
        cfg_valid <= 1'b0;
        src_idle_pct = 62;
        sink_idle_pct <= 12;
        run_random(PHASE_ITEMS / 2);
        drain_results();
        run_random(PHASE_ITEMS - PHASE_ITEMS / 2);
        drain_results();

        // No idling; the receiver holds off for a long stretch to fill the block.
        sync_setting = TYPE_W'($urandom_range(255));
        write_reg(comest_pkg::REG_SYNC_TYPE, CFG_DATA_W'(sync_setting));
        write_reg(comest_pkg::REG_UNSET_OFFSET, OFFSET_MIN);
        cfg_valid <= 1'b0;
        src_idle_pct = 0;
        sink_idle_pct <= 0;
        hold_request <= 1'b1;
        run_random(PHASE_ITEMS);
        drain_results();

        // Allow any stray result to surface before the verdict.
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (mismatch_count == 0 && outstanding == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule
